@@ rtl/core/ttps_pkg.sv @@
package ttps_pkg;

    // Table geometry
    localparam int INDEX_BITS = 12;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    // Field widths
    localparam int KEY_W     = 64;
    localparam int DEPTH_W   = 8;
    localparam int MOVE_W    = 16;
    localparam int SCORE_W   = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] MATE_MAG_RST   = CFG_W'(10000);
    localparam logic [CFG_W-1:0] REJECT_MAG_RST = CFG_W'(9900);

    typedef logic [INDEX_BITS-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_PROBE  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        BOUND_EXACT = 2'd0,
        BOUND_LOWER = 2'd1,
        BOUND_UPPER = 2'd2,
        BOUND_EMPTY = 2'd3
    } bound_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATE_MAG   = 1'b0,
        CFG_REJECT_MAG = 1'b1
    } cfg_reg_t;

    // One table slot
    typedef struct packed {
        logic [KEY_W-1:0]          key_primary;
        logic [KEY_W-1:0]          key_secondary;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        bound_t                    bound;
    } slot_t;

    // Table write and read requests
    typedef struct packed {
        logic      en;
        slot_idx_t addr;
        slot_t     data;
    } tbl_wr_t;

    typedef struct packed {
        logic      en;
        slot_idx_t addr;
    } tbl_rd_t;

    // Latched request item
    typedef struct packed {
        opcode_t                   opcode;
        logic [KEY_W-1:0]          key_primary;
        logic [KEY_W-1:0]          key_secondary;
        logic [DEPTH_W-1:0]        depth;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        bound_t                    bound;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } item_t;

    // Negate a configuration magnitude into a score
    function automatic logic signed [SCORE_W-1:0] neg_score(input logic [CFG_W-1:0] v);
        return SCORE_W'(0) - SCORE_W'(v);
    endfunction

endpackage

@@ rtl/core/ttps_ifs.sv @@
interface ttps_cfg_if;
    import ttps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface ttps_req_if;
    import ttps_pkg::*;
    logic                      valid;
    logic                      ready;
    opcode_t                   opcode;
    logic [KEY_W-1:0]          key_primary;
    logic [KEY_W-1:0]          key_secondary;
    logic [DEPTH_W-1:0]        search_depth;
    logic [MOVE_W-1:0]         move_in;
    logic signed [SCORE_W-1:0] score_in;
    bound_t                    bound_kind;
    logic signed [SCORE_W-1:0] alpha;
    logic signed [SCORE_W-1:0] beta;

    modport source (output valid, output opcode, output key_primary, output key_secondary,
                    output search_depth, output move_in, output score_in,
                    output bound_kind, output alpha, output beta, input ready);
    modport sink   (input valid, input opcode, input key_primary, input key_secondary,
                    input search_depth, input move_in, input score_in,
                    input bound_kind, input alpha, input beta, output ready);
endinterface

interface ttps_rsp_if;
    import ttps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      key_match;
    logic                      bound_hit;
    logic signed [SCORE_W-1:0] score_out;
    logic [MOVE_W-1:0]         move_out;
    logic [MOVE_W-1:0]         any_move_out;
    logic                      stored;

    modport source (output valid, output key_match, output bound_hit, output score_out,
                    output move_out, output any_move_out, output stored, input ready);
    modport sink   (input valid, input key_match, input bound_hit, input score_out,
                    input move_out, input any_move_out, input stored, output ready);
endinterface

@@ rtl/core/ttps_table.sv @@
module ttps_table (
    input  logic             clk,
    input  ttps_pkg::tbl_wr_t wr,
    input  ttps_pkg::tbl_rd_t rd,
    output ttps_pkg::slot_t   rd_data
);
    import ttps_pkg::*;

    slot_t mem [SLOT_COUNT];
    slot_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/transposition_table_probe_store.sv @@
// Channel | Direction | Transfer carries
// --------+-----------+---------------------------------------------------------
// cfg     | in        | index (0 mate magnitude, 1 reject magnitude), data (15 bits)
// req     | in        | opcode, keys, search_depth, move_in, score_in, bound_kind,
//         |           | alpha, beta
// rsp     | out       | key_match, bound_hit, score_out, move_out, any_move_out, stored
//
// Insert, probe and no-op run in two steps: the slot is read, then compared, written back
// and the result register loaded; the registered table read sets this split.
// Clear answers in the same two steps, then sweeps every slot (SLOT_COUNT, 4096), one per
// cycle, while req is held off. The same sweep runs after reset.
// A stalled rsp holds the finished result and stalls the next item in its compare step.
module transposition_table_probe_store (
    input  logic       clk,
    input  logic       rst_n,
    ttps_cfg_if.sink   cfg,
    ttps_req_if.sink   req,
    ttps_rsp_if.source rsp
);
    import ttps_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EVAL  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    slot_idx_t  clear_idx_reg, clear_idx_next;
    logic [CFG_W-1:0] mate_mag_reg, reject_mag_reg, clear_mate_reg, clear_mate_next;
    item_t      item_reg;
    logic       out_valid_reg, out_valid_next;

    logic                      out_match_reg, out_hit_reg, out_stored_reg;
    logic signed [SCORE_W-1:0] out_score_reg;
    logic [MOVE_W-1:0]         out_move_reg, out_any_move_reg;

    tbl_wr_t tbl_wr;
    tbl_rd_t tbl_rd;
    slot_t   cur;

    logic                      req_xfer, advance;
    logic                      keys_eq, depth_ok, bound_ok, hit, score_ok, replace, do_write;
    logic signed [SCORE_W-1:0] miss_score;
    slot_t                     new_slot, empty_slot;

    ttps_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd      (tbl_rd),
        .rd_data (cur)
    );

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mate_mag_reg   <= MATE_MAG_RST;
            reject_mag_reg <= REJECT_MAG_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_MATE_MAG:   mate_mag_reg   <= cfg.data;
                CFG_REJECT_MAG: reject_mag_reg <= cfg.data;
                default:        ;
            endcase
        end
    end

    // Handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign advance   = (state_reg == ST_EVAL) && (!out_valid_reg || rsp.ready);

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            item_reg.opcode        <= req.opcode;
            item_reg.key_primary   <= req.key_primary;
            item_reg.key_secondary <= req.key_secondary;
            item_reg.depth         <= req.search_depth;
            item_reg.move          <= req.move_in;
            item_reg.score         <= req.score_in;
            item_reg.bound         <= req.bound_kind;
            item_reg.alpha         <= req.alpha;
            item_reg.beta          <= req.beta;
        end
    end

    // Read the slot picked by the low key bits
    assign tbl_rd.en   = req_xfer;
    assign tbl_rd.addr = req.key_primary[INDEX_BITS-1:0];

    // Probe compare
    assign keys_eq  = (cur.key_primary == item_reg.key_primary)
                   && (cur.key_secondary == item_reg.key_secondary);
    assign depth_ok = (cur.depth >= item_reg.depth);

    always_comb
    begin
        case (cur.bound)
            BOUND_EXACT: bound_ok = 1'b1;
            BOUND_LOWER: bound_ok = (cur.score >= item_reg.beta);
            BOUND_UPPER: bound_ok = (cur.score <= item_reg.alpha);
            default:     bound_ok = 1'b0;
        endcase
    end

    assign hit        = keys_eq && depth_ok && bound_ok;
    assign miss_score = neg_score(mate_mag_reg);

    // Insert decision: score above minus the reject magnitude, and deeper or equal depth with a better score
    assign score_ok = (item_reg.score > neg_score(reject_mag_reg));
    assign replace  = (item_reg.depth > cur.depth)
                   || ((item_reg.depth == cur.depth) && (item_reg.score > cur.score));
    assign do_write = (item_reg.opcode == OP_INSERT) && score_ok && replace;

    always_comb
    begin
        new_slot.key_primary   = item_reg.key_primary;
        new_slot.key_secondary = item_reg.key_secondary;
        new_slot.depth         = item_reg.depth;
        new_slot.move          = item_reg.move;
        new_slot.score         = item_reg.score;
        new_slot.bound         = item_reg.bound;

        empty_slot.key_primary   = '0;
        empty_slot.key_secondary = '0;
        empty_slot.depth         = '0;
        empty_slot.move          = '0;
        empty_slot.score         = neg_score(clear_mate_reg);
        empty_slot.bound         = BOUND_EMPTY;
    end

    // Write back: sweep during clear, updated slot on a winning insert
    always_comb
    begin
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = clear_idx_reg;
        tbl_wr.data = empty_slot;
        if (state_reg == ST_CLEAR)
        begin
            tbl_wr.en = 1'b1;
        end
        else if (advance && do_write)
        begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = item_reg.key_primary[INDEX_BITS-1:0];
            tbl_wr.data = new_slot;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clear_idx_next  = clear_idx_reg;
        clear_mate_next = clear_mate_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + 1'b1;
                if (clear_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (advance)
                begin
                    if (item_reg.opcode == OP_CLEAR)
                    begin
                        state_next      = ST_CLEAR;
                        clear_idx_next  = '0;
                        clear_mate_next = mate_mag_reg;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_idx_reg  <= '0;
            clear_mate_reg <= MATE_MAG_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clear_idx_reg  <= clear_idx_next;
            clear_mate_reg <= clear_mate_next;
        end
    end

    // Result register: load on advance, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_match_reg    <= 1'b0;
            out_hit_reg      <= 1'b0;
            out_score_reg    <= miss_score;
            out_move_reg     <= '0;
            out_any_move_reg <= '0;
            out_stored_reg   <= do_write;
            if (item_reg.opcode == OP_PROBE)
            begin
                out_match_reg <= keys_eq;
                if (keys_eq)
                begin
                    out_any_move_reg <= cur.move;
                end
                if (hit)
                begin
                    out_hit_reg   <= 1'b1;
                    out_score_reg <= cur.score;
                    out_move_reg  <= cur.move;
                end
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.key_match    = out_match_reg;
    assign rsp.bound_hit    = out_hit_reg;
    assign rsp.score_out    = out_score_reg;
    assign rsp.move_out     = out_move_reg;
    assign rsp.any_move_out = out_any_move_reg;
    assign rsp.stored       = out_stored_reg;

endmodule
